// ===== src/haversine_distance_macros.svh =====
// Assertion macros for the haversine distance block.
// Used by the top level only; no other dependencies.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// same-cycle implication
`define HVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hvd_pkg.sv =====
// Package for the haversine distance block: widths, constants, item type,
// CORDIC arctangent table. No dependencies.
package hvd_pkg;

    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int DIST_W  = 23;
    localparam int ANG_W   = 33;   // Q24 degrees, signed
    localparam int ROT_W   = 33;   // rotation x/y, Q30 signed
    localparam int VEC_W   = 34;   // vectoring x/y, Q30 signed
    localparam int Q30_W   = 31;   // unsigned 0 .. 1.0
    localparam int SQ_W    = 62;   // integer square root working width
    localparam int STEPS   = 30;
    localparam int ISQ_STEPS = 31;

    localparam logic signed [ANG_W-1:0] LAT_MAX = 33'sd5898240;
    localparam logic signed [ANG_W-1:0] LON_MAX = 33'sd11796480;
    localparam logic signed [ANG_W-1:0] DEG90   = 33'sd1509949440;
    localparam logic signed [ANG_W-1:0] DEG180  = 33'sd3019898880;
    localparam logic signed [ROT_W-1:0] GAIN    = 33'sd652032874;
    localparam logic [Q30_W-1:0]        ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0]             DIST_SCALE = 32'd3731079249;
    localparam logic [DIST_W-1:0]       DIST_MAX   = 23'd5124023;

    typedef struct packed {
        logic signed [ANG_W-1:0] la;
        logic signed [ANG_W-1:0] lb;
        logic signed [ANG_W-1:0] hlat;
        logic signed [ANG_W-1:0] hlon;
    } hvd_item_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } hvd_qstat_t;

    // atan(2^-i) in Q24 degrees
    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0:  r = 33'sd754974720;
            1:  r = 33'sd445687602;
            2:  r = 33'sd235489088;
            3:  r = 33'sd119537938;
            4:  r = 33'sd60000934;
            5:  r = 33'sd30029717;
            6:  r = 33'sd15018523;
            7:  r = 33'sd7509720;
            8:  r = 33'sd3754917;
            9:  r = 33'sd1877466;
            10: r = 33'sd938734;
            11: r = 33'sd469367;
            12: r = 33'sd234684;
            13: r = 33'sd117342;
            14: r = 33'sd58671;
            15: r = 33'sd29335;
            16: r = 33'sd14668;
            17: r = 33'sd7334;
            18: r = 33'sd3667;
            19: r = 33'sd1833;
            20: r = 33'sd917;
            21: r = 33'sd458;
            22: r = 33'sd229;
            23: r = 33'sd115;
            24: r = 33'sd57;
            25: r = 33'sd29;
            26: r = 33'sd14;
            27: r = 33'sd7;
            28: r = 33'sd4;
            29: r = 33'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/hvd_in_if.sv =====
// Input channel: one point pair per beat.
// Depends on hvd_pkg for field widths.
interface hvd_in_if;
    import hvd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
    modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
    modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

// ===== src/hvd_out_if.sv =====
// Output channel: one distance per beat.
// Depends on hvd_pkg for field widths.
interface hvd_out_if;
    import hvd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance_km;
    modport source (output valid, distance_km, input ready);
    modport sink   (input valid, distance_km, output ready);
endinterface

// ===== src/hvd_front.sv =====
// Front end: accepts point pairs, saturates angles, forms Q24 angles and
// half differences with longitude wrap. Depends on hvd_pkg, hvd_in_if.
module hvd_front (
    input  logic              clk,
    input  logic              rst_n,
    hvd_in_if.sink            pair,
    output logic              item_valid,
    input  logic              item_ready,
    output hvd_pkg::hvd_item_t item
);
    import hvd_pkg::*;

    logic               f_v_reg;
    hvd_item_t          f_item_reg;
    hvd_item_t          f_item_next;
    logic               take;

    function automatic logic signed [ANG_W-1:0] sat(input logic signed [ANG_W-1:0] v,
                                                    input logic signed [ANG_W-1:0] lim);
        logic signed [ANG_W-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r <<< 8;
    endfunction

    logic signed [ANG_W-1:0] oa, ob;
    logic signed [ANG_W:0]   dlon;
    logic signed [ANG_W-1:0] hl;

    always_comb
    begin
        f_item_next.la = sat({{(ANG_W-LAT_W){pair.lat_a[LAT_W-1]}}, pair.lat_a}, LAT_MAX);
        f_item_next.lb = sat({{(ANG_W-LAT_W){pair.lat_b[LAT_W-1]}}, pair.lat_b}, LAT_MAX);
        oa = sat({{(ANG_W-LON_W){pair.lon_a[LON_W-1]}}, pair.lon_a}, LON_MAX);
        ob = sat({{(ANG_W-LON_W){pair.lon_b[LON_W-1]}}, pair.lon_b}, LON_MAX);
        // differences of multiples of 256 are even, so the shift is exact
        f_item_next.hlat = (f_item_next.lb - f_item_next.la) >>> 1;
        dlon = {ob[ANG_W-1], ob} - {oa[ANG_W-1], oa};
        hl = dlon[ANG_W:1];
        if (hl > DEG90)
            f_item_next.hlon = hl - DEG180;
        else if (hl < -DEG90)
            f_item_next.hlon = hl + DEG180;
        else
            f_item_next.hlon = hl;
    end

    assign pair.ready = !f_v_reg || item_ready;
    assign take       = pair.valid && pair.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (pair.ready)
        begin
            f_v_reg <= pair.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign item_valid = f_v_reg;
    assign item       = f_item_reg;

endmodule

// ===== src/hvd_queue.sv =====
// Short FIFO between front end and math pipeline.
// Depends on hvd_pkg.
module hvd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  hvd_pkg::hvd_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output hvd_pkg::hvd_item_t pop_item,
    output hvd_pkg::hvd_qstat_t stat
);
    import hvd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hvd_item_t     mem [DEPTH];
    hvd_item_t     head_reg;
    logic [PW-1:0] wr_reg, rd_reg, rd_inc;
    logic [CW-1:0] cnt_reg;
    logic          push, pop, full, empty;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign empty      = (cnt_reg == '0);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign push       = push_valid && !full;
    assign pop        = pop_ready && !empty;
    assign rd_inc     = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign pop_item   = head_reg;
    assign stat       = '{push: push, pop: pop, full: full, empty: empty};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_inc;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // head entry lives in a register; a pop refills it from the next slot
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
        if (push && (empty || (pop && cnt_reg == CW'(1))))
            head_reg <= push_item;
        else if (pop && cnt_reg != CW'(1))
            head_reg <= mem[rd_inc];
    end

endmodule

// ===== src/hvd_back.sv =====
// Math pipeline: four rotation CORDICs, haversine products, two pipelined
// square roots, vectoring CORDIC, scaling. Depends on hvd_pkg, hvd_out_if.
module hvd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  hvd_pkg::hvd_item_t item,
    hvd_out_if.source          result
);
    import hvd_pkg::*;

    localparam int NST = (STEPS + 1) + 3 + (ISQ_STEPS + 1) + (STEPS + 1) + 2;

    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv        = !vld_reg[NST-1] || result.ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], item_valid};
    end

    // rotation CORDIC, lanes: la, lb, hlat, hlon
    logic signed [ROT_W-1:0] rx_reg [4][STEPS+1];
    logic signed [ROT_W-1:0] ry_reg [4][STEPS+1];
    logic signed [ANG_W-1:0] rz_reg [4][STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rx_reg[l][0] <= GAIN;
                ry_reg[l][0] <= '0;
            end
            rz_reg[0][0] <= item.la;
            rz_reg[1][0] <= item.lb;
            rz_reg[2][0] <= item.hlat;
            rz_reg[3][0] <= item.hlon;
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_rot_lane
        for (genvar s = 0; s < STEPS; s++)
        begin : g_rot_step
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!rz_reg[l][s][ANG_W-1])
                    begin
                        rx_reg[l][s+1] <= rx_reg[l][s] - (ry_reg[l][s] >>> s);
                        ry_reg[l][s+1] <= ry_reg[l][s] + (rx_reg[l][s] >>> s);
                        rz_reg[l][s+1] <= rz_reg[l][s] - atan_deg(s);
                    end
                    else
                    begin
                        rx_reg[l][s+1] <= rx_reg[l][s] + (ry_reg[l][s] >>> s);
                        ry_reg[l][s+1] <= ry_reg[l][s] - (rx_reg[l][s] >>> s);
                        rz_reg[l][s+1] <= rz_reg[l][s] + atan_deg(s);
                    end
                end
            end
        end
    end

    function automatic logic [Q30_W-1:0] mag(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] m;
        m = v[ROT_W-1] ? -v : v;
        return (m > $signed({2'b00, ONE_Q30})) ? ONE_Q30 : m[Q30_W-1:0];
    endfunction

    function automatic logic [Q30_W-1:0] cosc(input logic signed [ROT_W-1:0] v);
        logic [Q30_W-1:0] r;
        if (v[ROT_W-1])
            r = '0;
        else if (v > $signed({2'b00, ONE_Q30}))
            r = ONE_Q30;
        else
            r = v[Q30_W-1:0];
        return r;
    endfunction

    // haversine products
    logic [Q30_W-1:0]     su_m, sv_m, c1_c, c2_c;
    logic [2*Q30_W-1:0]   pa, pb, pc, pd;
    logic [Q30_W-1:0]     a1_reg, b0_reg, cc_reg, a2_reg, b_reg, h_reg;
    logic [Q30_W:0]       hsum;

    assign su_m = mag(ry_reg[2][STEPS]);
    assign sv_m = mag(ry_reg[3][STEPS]);
    assign c1_c = cosc(rx_reg[0][STEPS]);
    assign c2_c = cosc(rx_reg[1][STEPS]);
    assign pa   = su_m * su_m;
    assign pb   = sv_m * sv_m;
    assign pc   = c1_c * c2_c;
    assign pd   = cc_reg * b0_reg;
    assign hsum = {1'b0, a2_reg} + {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= pa[2*Q30_W-2:Q30_W-1];
            b0_reg <= pb[2*Q30_W-2:Q30_W-1];
            cc_reg <= pc[2*Q30_W-2:Q30_W-1];
            a2_reg <= a1_reg;
            b_reg  <= pd[2*Q30_W-2:Q30_W-1];
            h_reg  <= (hsum > {1'b0, ONE_Q30}) ? ONE_Q30 : hsum[Q30_W-1:0];
        end
    end

    // square roots, lane 0: h, lane 1: 1 - h; one result bit per stage
    logic [SQ_W-1:0] qv_reg [2][ISQ_STEPS+1];
    logic [SQ_W-1:0] qr_reg [2][ISQ_STEPS+1];
    logic [Q30_W-1:0] h_c;

    assign h_c = ONE_Q30 - h_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qv_reg[0][0] <= {1'b0, h_reg, 30'b0};
            qv_reg[1][0] <= {1'b0, h_c, 30'b0};
            qr_reg[0][0] <= '0;
            qr_reg[1][0] <= '0;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_sq_lane
        for (genvar j = 0; j < ISQ_STEPS; j++)
        begin : g_sq_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
            logic [SQ_W-1:0] rb;
            assign rb = qr_reg[l][j] + BIT;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (qv_reg[l][j] >= rb)
                    begin
                        qv_reg[l][j+1] <= qv_reg[l][j] - rb;
                        qr_reg[l][j+1] <= (qr_reg[l][j] >> 1) + BIT;
                    end
                    else
                    begin
                        qv_reg[l][j+1] <= qv_reg[l][j];
                        qr_reg[l][j+1] <= qr_reg[l][j] >> 1;
                    end
                end
            end
        end
    end

    // vectoring CORDIC: angle of (sqrt(1-h), sqrt(h))
    logic signed [VEC_W-1:0] vx_reg [STEPS+1];
    logic signed [VEC_W-1:0] vy_reg [STEPS+1];
    logic signed [ANG_W-1:0] vz_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0] <= $signed({{(VEC_W-Q30_W){1'b0}}, qr_reg[1][ISQ_STEPS][Q30_W-1:0]});
            vy_reg[0] <= $signed({{(VEC_W-Q30_W){1'b0}}, qr_reg[0][ISQ_STEPS][Q30_W-1:0]});
            vz_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < STEPS; s++)
    begin : g_vec_step
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!vy_reg[s][VEC_W-1])
                begin
                    vx_reg[s+1] <= vx_reg[s] + (vy_reg[s] >>> s);
                    vy_reg[s+1] <= vy_reg[s] - (vx_reg[s] >>> s);
                    vz_reg[s+1] <= vz_reg[s] + atan_deg(s);
                end
                else
                begin
                    vx_reg[s+1] <= vx_reg[s] - (vy_reg[s] >>> s);
                    vy_reg[s+1] <= vy_reg[s] + (vx_reg[s] >>> s);
                    vz_reg[s+1] <= vz_reg[s] - atan_deg(s);
                end
            end
        end
    end

    // scale angle to km, round half up, saturate
    logic [ANG_W-2:0]  theta;
    logic [63:0]       prod_reg;
    logic [63:0]       rnd;
    logic [DIST_W-1:0] dist_reg;

    assign theta = vz_reg[STEPS][ANG_W-1] ? '0 : vz_reg[STEPS][ANG_W-2:0];
    assign rnd   = prod_reg + (64'd1 << 39);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= theta * DIST_SCALE;
            dist_reg <= (rnd[63:40] > {1'b0, DIST_MAX}) ? DIST_MAX : rnd[62:40];
        end
    end

    assign result.valid       = vld_reg[NST-1];
    assign result.distance_km = dist_reg;

endmodule

// ===== src/haversine_distance.sv =====
// Top level of the haversine distance block: front end, queue, math pipeline.
// Depends on hvd_pkg, hvd_in_if, hvd_out_if, hvd_front, hvd_queue, hvd_back.

// Takes one point pair per beat and returns its great-circle distance in km
// (8 fraction bits) one beat per pair, in order, one pair per cycle while the
// output is not stalled. A pair passes the front-end register, the queue head
// register and 99 pipeline stages: the 30-step rotation CORDIC, the products,
// the 31-step square root, the 30-step vectoring CORDIC and the scaling, each
// step a stage, plus loading registers. A stalled output freezes the math
// pipeline; the queue of QDEPTH pairs keeps the input side taking beats.
module haversine_distance #(
    parameter int QDEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    hvd_in_if.sink      pair,
    hvd_out_if.source   result
);
    import hvd_pkg::*;

    `include "haversine_distance_macros.svh"

    logic       f_valid, f_ready, q_valid, q_ready;
    hvd_item_t  f_item, q_item;
    hvd_qstat_t qstat;

    hvd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    hvd_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item),
        .stat       (qstat)
    );

    hvd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .result     (result)
    );

    `HVD_ASSERT_IMP(a_dist_range, clk, rst_n, result.valid,
        result.distance_km <= DIST_MAX, "distance beyond range")
    `HVD_ASSERT_NXT(a_empty_holds, clk, rst_n, qstat.empty && !qstat.push,
        qstat.empty, "queue filled without a push")
    `HVD_ASSERT_NXT(a_full_holds, clk, rst_n, qstat.full && !qstat.pop,
        qstat.full, "queue drained without a pop")

endmodule

// ===== verif/tb_haversine_distance.sv =====
// Testbench for haversine_distance: random and directed point pairs, self-checking.
// Depends on hvd_pkg, hvd_in_if, hvd_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_haversine_distance;
    import hvd_pkg::*;

    localparam int  N_RANDOM    = 1450;
    localparam int  HOLD_CYCLES = 400;
    localparam int  DRAIN_WAIT  = 150;
    localparam longint LIMIT    = 400000;

    typedef struct {
        logic signed [LAT_W-1:0] lat_a;
        logic signed [LON_W-1:0] lon_a;
        logic signed [LAT_W-1:0] lat_b;
        logic signed [LON_W-1:0] lon_b;
    } pair_t;

    logic clk;
    logic rst_n;
    hvd_in_if  pair_ch();
    hvd_out_if dist_ch();

    haversine_distance u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch.sink),
        .result (dist_ch.source)
    );

    pair_t             pending_pairs[$];
    logic [DIST_W-1:0] expected_dist[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_go;
    bit  hold_on;
    bit  failed;
    bit  stim_done;
    longint cycle_count;

    // CORDIC arctangents, degrees * 2^24
    function automatic longint atan_q24(int i);
        longint t[30] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7, 4, 2};
        return t[i];
    endfunction

    function automatic void rotate(longint ang, output longint sn, output longint cs);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0)
            begin
                x -= dx; y += dy; ang -= atan_q24(i);
            end
            else
            begin
                x += dx; y -= dy; ang += atan_q24(i);
            end
        end
        sn = y;
        cs = x;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_q24(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_q24(i);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic longint unsigned unit_mag(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return (m > (64'd1 << 30)) ? (64'd1 << 30) : m;
    endfunction

    function automatic longint unsigned unit_pos(longint v);
        if (v < 0) return 0;
        return (v > (64'sd1 << 30)) ? (64'd1 << 30) : v;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_km(pair_t p);
        longint la, oa, lb, ob, hlat, hlon;
        longint s1, c1, s2, c2, su, cu, sv, cv, theta;
        longint unsigned a, b, h, rs, rc, d;
        longint unsigned one;
        one = 64'd1 << 30;
        la = sat(longint'(p.lat_a), 5898240) * 256;
        oa = sat(longint'(p.lon_a), 11796480) * 256;
        lb = sat(longint'(p.lat_b), 5898240) * 256;
        ob = sat(longint'(p.lon_b), 11796480) * 256;
        hlat = (lb - la) / 2;
        hlon = (ob - oa) / 2;
        if (hlon > 64'sd1509949440) hlon -= 64'sd3019898880;
        else if (hlon < -64'sd1509949440) hlon += 64'sd3019898880;
        rotate(la, s1, c1);
        rotate(lb, s2, c2);
        rotate(hlat, su, cu);
        rotate(hlon, sv, cv);
        a = unit_mag(su);
        a = (a * a) >> 30;
        b = unit_mag(sv);
        b = (b * b) >> 30;
        b = (((unit_pos(c1) * unit_pos(c2)) >> 30) * b) >> 30;
        h = a + b;
        if (h > one) h = one;
        rs = int_sqrt(h << 30);
        rc = int_sqrt((one - h) << 30);
        theta = vector_angle(longint'(rc), longint'(rs));
        if (theta < 0) theta = 0;
        // theta < 2^32 and scale < 2^32, so the product fits in 64 bits
        d = (longint'(theta) * 64'd3731079249 + (64'd1 << 39)) >> 40;
        if (d > 64'd5124023) d = 64'd5124023;
        return d[DIST_W-1:0];
    endfunction

    function automatic pair_t make_pair(longint la, longint oa, longint lb, longint ob);
        pair_t p;
        p.lat_a = la[LAT_W-1:0];
        p.lon_a = oa[LON_W-1:0];
        p.lat_b = lb[LAT_W-1:0];
        p.lon_b = ob[LON_W-1:0];
        return p;
    endfunction

    function automatic longint rand_lat();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return longint'($signed(24'($urandom)));
        if (k == 1) return ($urandom_range(0, 1) ? 5898240 : -5898240);
        return longint'($urandom_range(0, 11796480)) - 5898240;
    endfunction

    function automatic longint rand_lon();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return longint'($signed(25'($urandom)));
        if (k == 1) return ($urandom_range(0, 1) ? 11796480 : -11796480);
        return longint'($urandom_range(0, 23592960)) - 11796480;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // stimulus
    initial
    begin
        longint la;
        longint oa;
        send_idle_pct = 35;
        recv_idle_pct = 86;
        hold_go = 1'b0;
        stim_done = 1'b0;
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(5898240, 0, -5898240, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 11796480));
        pending_pairs.push_back(make_pair(0, -11796480, 0, 11796480));
        pending_pairs.push_back(make_pair(0, 11796480, 0, -11796480));
        pending_pairs.push_back(make_pair(5898240, 0, 5898240, 11796480));
        pending_pairs.push_back(make_pair(-5898240, -11796480, -5898240, 11796480));
        pending_pairs.push_back(make_pair(0, 0, 0, 11796479));
        pending_pairs.push_back(make_pair(0, 0, 0, 5898240));
        pending_pairs.push_back(make_pair(0, 0, 0, 5898241));
        pending_pairs.push_back(make_pair(0, -5898241, 0, 5898240));
        pending_pairs.push_back(make_pair(-8388608, -16777216, 8388607, 16777215));
        pending_pairs.push_back(make_pair(8388607, 16777215, -8388608, -16777216));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1));
        pending_pairs.push_back(make_pair(1, 1, 0, 0));
        pending_pairs.push_back(make_pair(2621440, 655360, 2621441, 655360));
        pending_pairs.push_back(make_pair(1000000, 2000000, -1000000, -9796480));
        pending_pairs.push_back(make_pair(5898239, 123456, 5898240, -7654321));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                while (pending_pairs.size() != 0) @(posedge clk);
                send_idle_pct = 86;
                recv_idle_pct = 35;
            end
            else if (i == 2 * N_RANDOM / 3)
            begin
                while (pending_pairs.size() != 0) @(posedge clk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_go = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                // nearby points and antipodal neighbours stress the rounding edges
                la = rand_lat();
                oa = rand_lon();
                if ($urandom_range(0, 1))
                    pending_pairs.push_back(make_pair(la, oa,
                        la + $signed($urandom_range(0, 64)) - 32,
                        oa + $signed($urandom_range(0, 64)) - 32));
                else
                    pending_pairs.push_back(make_pair(la, oa, -la,
                        oa > 0 ? oa - 11796480 : oa + 11796480));
            end
            else
                pending_pairs.push_back(make_pair(rand_lat(), rand_lon(),
                    rand_lat(), rand_lon()));
        end
        while (pending_pairs.size() != 0) @(posedge clk);
        stim_done = 1'b1;
    end

    // long receiver stall while the sender keeps offering beats
    initial
    begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // sender: retire the accepted beat, then present the next head item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_ch.valid <= 1'b0;
            pair_ch.lat_a <= '0;
            pair_ch.lon_a <= '0;
            pair_ch.lat_b <= '0;
            pair_ch.lon_b <= '0;
        end
        else
        begin
            if (pair_ch.valid && pair_ch.ready)
                expected_dist.push_back(great_circle_km(pending_pairs.pop_front()));
            if (!pair_ch.valid || pair_ch.ready)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    pair_ch.valid <= 1'b1;
                    pair_ch.lat_a <= pending_pairs[0].lat_a;
                    pair_ch.lon_a <= pending_pairs[0].lon_a;
                    pair_ch.lat_b <= pending_pairs[0].lat_b;
                    pair_ch.lon_b <= pending_pairs[0].lon_b;
                end
                else
                    pair_ch.valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        logic [DIST_W-1:0] want;
        if (!rst_n)
        begin
            dist_ch.ready <= 1'b0;
            failed = 1'b0;
        end
        else
        begin
            if (dist_ch.valid && dist_ch.ready)
            begin
                if (expected_dist.size() == 0)
                begin
                    $error("unexpected distance_km beat: %0d", dist_ch.distance_km);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_dist.pop_front();
                    if (dist_ch.distance_km !== want)
                    begin
                        $error("distance_km expected %0d actual %0d", want,
                            dist_ch.distance_km);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_on)
                dist_ch.ready <= 1'b0;
            else
                dist_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        pair_ch.valid = 1'b0;
        pair_ch.lat_a = '0;
        pair_ch.lon_a = '0;
        pair_ch.lat_b = '0;
        pair_ch.lon_b = '0;
        dist_ch.ready = 1'b0;
    end

    // end of run
    initial
    begin
        cycle_count = 0;
        fork
            begin
                wait (stim_done && !pair_ch.valid);
                while (expected_dist.size() != 0) @(posedge clk);
                repeat (DRAIN_WAIT) @(posedge clk);
                if (!failed)
                    $display("SCOREBOARD CLEAN");
                else
                    $display("SCOREBOARD MISMATCH");
                $finish;
            end
            begin
                while (cycle_count < LIMIT)
                begin
                    @(posedge clk);
                    cycle_count++;
                end
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        join
    end

endmodule
